### hdl/sld_pkg.sv
`timescale 1ns / 1ps

package sld_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h5A;
    localparam logic [7:0] TAIL_BYTE = 8'hA5;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_GOOD     = 2'd1;
    localparam logic [1:0] KIND_BAD_TAIL = 2'd2;
    localparam logic [1:0] KIND_OVERSIZE = 2'd3;

    localparam logic       CFG_STATE_TYPE  = 1'b0;
    localparam logic       CFG_MAX_PAYLOAD = 1'b1;

    localparam logic [7:0]  STATE_TYPE_RESET  = 8'd0;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd504;

    typedef struct packed {
        logic [7:0]  state_type_code;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [15:0] payload_index;
        logic [7:0]  frame_type;
        logic [7:0]  frame_seq;
        logic        type_match;
    } result_t;

endpackage

### hdl/sld_in_reg.sv
`timescale 1ns / 1ps

module sld_in_reg (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       consume,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Held byte leaves as next enters: a byte can move each cycle consume is high.
    assign s_tready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        byte_next  = byte_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
            byte_next  = s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        byte_reg <= byte_next;
    end

    assign byte_valid = valid_reg;
    assign byte_data  = byte_reg;

endmodule

### hdl/sld_parser.sv
`timescale 1ns / 1ps

module sld_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  sld_pkg::cfg_t     cfg,
    input  logic              byte_valid,
    input  logic [7:0]        byte_data,
    input  logic              out_free,
    output logic              consume,
    output logic              res_valid,
    output sld_pkg::result_t  res
);

    typedef enum logic [3:0] {
        PH_HUNT1   = 4'd0,
        PH_HUNT2   = 4'd1,
        PH_SEQ     = 4'd2,
        PH_TYPE    = 4'd3,
        PH_LEN_LO  = 4'd4,
        PH_LEN_HI  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_TAIL1   = 4'd7,
        PH_TAIL2   = 4'd8
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  seq_reg;
    logic [7:0]  seq_next;
    logic [7:0]  type_reg;
    logic [7:0]  type_next;
    logic [15:0] length_reg;
    logic [15:0] length_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic        tail_bad_reg;
    logic        tail_bad_next;

    logic [15:0] full_length;
    logic [15:0] count_inc;
    logic        emits;
    logic        bad_byte;

    assign full_length = {byte_data, length_reg[7:0]};
    assign count_inc   = count_reg + 16'd1;
    assign bad_byte    = (byte_data != sld_pkg::TAIL_BYTE);

    always_comb begin
        unique case (phase_reg)
            PH_PAYLOAD: emits = 1'b1;
            PH_TAIL2:   emits = 1'b1;
            PH_LEN_HI:  emits = (full_length > cfg.max_payload);
            default:    emits = 1'b0;
        endcase
    end

    // A byte that yields a result waits until the output register has room.
    assign consume   = byte_valid && (!emits || out_free);
    assign res_valid = consume && emits;

    always_comb begin
        phase_next    = phase_reg;
        seq_next      = seq_reg;
        type_next     = type_reg;
        length_next   = length_reg;
        count_next    = count_reg;
        tail_bad_next = tail_bad_reg;

        res.kind          = sld_pkg::KIND_PAYLOAD;
        res.data_byte     = 8'd0;
        res.payload_index = length_reg;
        res.frame_type    = type_reg;
        res.frame_seq     = seq_reg;
        res.type_match    = (type_reg == cfg.state_type_code);

        unique case (phase_reg)
            PH_HUNT2: begin
                phase_next = (byte_data == sld_pkg::SYNC_BYTE) ? PH_SEQ : PH_HUNT1;
            end
            PH_SEQ: begin
                seq_next   = byte_data;
                phase_next = PH_TYPE;
            end
            PH_TYPE: begin
                type_next  = byte_data;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                length_next = {8'd0, byte_data};
                phase_next  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                length_next       = full_length;
                count_next        = 16'd0;
                tail_bad_next     = 1'b0;
                res.kind          = sld_pkg::KIND_OVERSIZE;
                res.payload_index = full_length;
                if (full_length > cfg.max_payload) begin
                    phase_next = PH_HUNT1;
                end else if (full_length == 16'd0) begin
                    phase_next = PH_TAIL1;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                res.kind          = sld_pkg::KIND_PAYLOAD;
                res.data_byte     = byte_data;
                res.payload_index = count_reg;
                count_next        = count_inc;
                if (count_inc >= length_reg) begin
                    phase_next = PH_TAIL1;
                end
            end
            PH_TAIL1: begin
                tail_bad_next = bad_byte;
                phase_next    = PH_TAIL2;
            end
            PH_TAIL2: begin
                tail_bad_next = tail_bad_reg || bad_byte;
                res.kind      = tail_bad_next ? sld_pkg::KIND_BAD_TAIL : sld_pkg::KIND_GOOD;
                phase_next    = PH_HUNT1;
            end
            default: begin
                phase_next = (byte_data == sld_pkg::SYNC_BYTE) ? PH_HUNT2 : PH_HUNT1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HUNT1;
            seq_reg      <= 8'd0;
            type_reg     <= 8'd0;
            length_reg   <= 16'd0;
            count_reg    <= 16'd0;
            tail_bad_reg <= 1'b0;
        end else if (consume) begin
            phase_reg    <= phase_next;
            seq_reg      <= seq_next;
            type_reg     <= type_next;
            length_reg   <= length_next;
            count_reg    <= count_next;
            tail_bad_reg <= tail_bad_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> count_reg < length_reg)
        else $error("payload count reached the frame length inside the payload");

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res.kind != sld_pkg::KIND_PAYLOAD |-> res.data_byte == 8'd0)
        else $error("frame end result carries a data byte");

    assert property (@(posedge aclk) disable iff (!aresetn)
        consume && phase_reg == PH_PAYLOAD && phase_next == PH_PAYLOAD
        |=> count_reg == $past(count_reg) + 16'd1)
        else $error("payload count did not advance by one");

    assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid |-> out_free)
        else $error("result issued while the output register was full");

endmodule

### hdl/sld_out_reg.sv
`timescale 1ns / 1ps

module sld_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    input  sld_pkg::result_t res,
    output logic             out_free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,
    output logic [1:0]       m_tuser
);

    logic             valid_reg;
    logic             valid_next;
    sld_pkg::result_t res_reg;
    sld_pkg::result_t res_next;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (out_free) begin
            valid_next = res_valid;
            res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {7'd0, res_reg.type_match, res_reg.frame_seq, res_reg.frame_type,
                       res_reg.payload_index, res_reg.data_byte};

endmodule

### hdl/sync_length_frame_deframer.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake           Contents
// s_       in         s_tvalid/s_tready   tdata: rx_byte
// m_       out        m_tvalid/m_tready   tdata: fields below; tuser: kind
// cfg_     in         cfg_we              cfg_index selects the register, cfg_wdata value
//
// One byte is accepted per cycle unless its result is stalled at the output.
// The rate is set by the single parse step between the input and output registers.
// Reset (aresetn low at a clock edge) returns the parser to sync hunting and
// loads the register defaults. A stalled result output holds only bytes that
// yield a result; other bytes keep flowing.

module sync_length_frame_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,    // [7:0] data_byte, [23:8] payload_index,
                                    // [31:24] frame_type, [39:32] frame_seq,
                                    // [40] type_match, [47:41] zero
    output logic [1:0]  m_tuser,    // [1:0] kind
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    sld_pkg::cfg_t    cfg_reg;
    sld_pkg::cfg_t    cfg_next;
    sld_pkg::result_t res;
    logic             byte_valid;
    logic [7:0]       byte_data;
    logic             consume;
    logic             res_valid;
    logic             out_free;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_index)
                sld_pkg::CFG_STATE_TYPE:  cfg_next.state_type_code = cfg_wdata[7:0];
                sld_pkg::CFG_MAX_PAYLOAD: cfg_next.max_payload     = cfg_wdata;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.state_type_code <= sld_pkg::STATE_TYPE_RESET;
            cfg_reg.max_payload     <= sld_pkg::MAX_PAYLOAD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    sld_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .consume    (consume),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    sld_parser u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .out_free   (out_free),
        .consume    (consume),
        .res_valid  (res_valid),
        .res        (res)
    );

    sld_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### test/sync_length_frame_deframer_tb.sv
`timescale 1ns / 1ps

module sync_length_frame_deframer_tb;

    localparam int HOLD_CYCLES = 200;
    localparam int DRAIN_LIMIT = 100000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS = 256;

    typedef enum logic [3:0] {
        POS_HUNT1, POS_HUNT2, POS_SEQ, POS_TYPE, POS_LEN_LO,
        POS_LEN_HI, POS_PAYLOAD, POS_TAIL1, POS_TAIL2
    } frame_pos_t;

    typedef struct packed {
        logic [7:0]       rx;
        logic             typed;
        sld_pkg::result_t want;
    } dir_row_t;

    localparam sld_pkg::result_t NO_RESULT = '0;

    // Rows marked typed carry the result that the byte must close out with.
    localparam dir_row_t DIRECTED [26] = '{
        '{8'h5A, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h02, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hA5, 1'b0, NO_RESULT},
        '{8'hA5, 1'b1, '{sld_pkg::KIND_GOOD, 8'h00, 16'd2, 8'h00, 8'h5A, 1'b1}},
        '{8'h5A, 1'b0, NO_RESULT},
        '{8'h13, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'h07, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hA5, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{sld_pkg::KIND_BAD_TAIL, 8'h00, 16'd0, 8'h07, 8'h01, 1'b0}},
        '{8'h5A, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, NO_RESULT},
        '{8'h80, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, '{sld_pkg::KIND_OVERSIZE, 8'h00, 16'hFFFF, 8'hFF, 8'h80, 1'b0}}
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic        cfg_index = sld_pkg::CFG_STATE_TYPE;
    logic [15:0] cfg_wdata = 16'h0000;

    frame_pos_t  frame_pos = POS_HUNT1;
    logic [7:0]  hdr_seq = 8'h00;
    logic [7:0]  hdr_type = 8'h00;
    logic [15:0] hdr_len = 16'h0000;
    logic [15:0] payload_count = 16'h0000;
    logic        tail_err = 1'b0;
    logic [7:0]  shadow_state_type = sld_pkg::STATE_TYPE_RESET;
    logic [15:0] shadow_max_payload = sld_pkg::MAX_PAYLOAD_RESET;

    sld_pkg::result_t pending_results[$];
    logic             row_typed = 1'b0;
    sld_pkg::result_t row_want = '0;
    logic             long_hold = 1'b0;
    event             hold_ev;
    int               send_idle_pct = 0;
    int               stall_pct = 0;
    int               items_sent = 0;
    int               mismatch_count = 0;
    int               kind_count [4] = '{0, 0, 0, 0};

    sync_length_frame_deframer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic sld_pkg::result_t frame_result(input logic [1:0] kind,
                                                      input logic [7:0] data,
                                                      input logic [15:0] index);
        sld_pkg::result_t r;
        r.kind          = kind;
        r.data_byte     = data;
        r.payload_index = index;
        r.frame_type    = hdr_type;
        r.frame_seq     = hdr_seq;
        r.type_match    = (hdr_type == shadow_state_type);
        return r;
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b, output logic fires,
                                 output sld_pkg::result_t r);
        fires = 1'b0;
        r = '0;
        case (frame_pos)
            POS_HUNT2: begin
                frame_pos = (b == sld_pkg::SYNC_BYTE) ? POS_SEQ : POS_HUNT1;
            end
            POS_SEQ: begin
                hdr_seq = b;
                frame_pos = POS_TYPE;
            end
            POS_TYPE: begin
                hdr_type = b;
                frame_pos = POS_LEN_LO;
            end
            POS_LEN_LO: begin
                hdr_len = {8'h00, b};
                frame_pos = POS_LEN_HI;
            end
            POS_LEN_HI: begin
                hdr_len = {b, hdr_len[7:0]};
                payload_count = 16'h0000;
                tail_err = 1'b0;
                if (hdr_len > shadow_max_payload) begin
                    frame_pos = POS_HUNT1;
                    fires = 1'b1;
                    r = frame_result(sld_pkg::KIND_OVERSIZE, 8'h00, hdr_len);
                end else begin
                    frame_pos = (hdr_len == 16'h0000) ? POS_TAIL1 : POS_PAYLOAD;
                end
            end
            POS_PAYLOAD: begin
                fires = 1'b1;
                r = frame_result(sld_pkg::KIND_PAYLOAD, b, payload_count);
                payload_count = payload_count + 16'd1;
                if (payload_count >= hdr_len)
                    frame_pos = POS_TAIL1;
            end
            POS_TAIL1: begin
                tail_err = (b != sld_pkg::TAIL_BYTE);
                frame_pos = POS_TAIL2;
            end
            POS_TAIL2: begin
                if (b != sld_pkg::TAIL_BYTE)
                    tail_err = 1'b1;
                frame_pos = POS_HUNT1;
                fires = 1'b1;
                r = frame_result(tail_err ? sld_pkg::KIND_BAD_TAIL : sld_pkg::KIND_GOOD,
                                 8'h00, hdr_len);
            end
            default: begin
                frame_pos = (b == sld_pkg::SYNC_BYTE) ? POS_HUNT2 : POS_HUNT1;
            end
        endcase
    endtask

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            flag_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    always @(posedge aclk) begin
        logic             fires;
        sld_pkg::result_t pred;
        sld_pkg::result_t got;
        sld_pkg::result_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got.kind          = m_tuser;
                got.data_byte     = m_tdata[7:0];
                got.payload_index = m_tdata[23:8];
                got.frame_type    = m_tdata[31:24];
                got.frame_seq     = m_tdata[39:32];
                got.type_match    = m_tdata[40];
                kind_count[got.kind]++;
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("result of kind %0d with index %0d not expected",
                                            got.kind, got.payload_index));
                end else begin
                    want = pending_results.pop_front();
                    compare_field("kind", int'(got.kind), int'(want.kind));
                    compare_field("data_byte", int'(got.data_byte), int'(want.data_byte));
                    compare_field("payload_index", int'(got.payload_index),
                                  int'(want.payload_index));
                    compare_field("frame_type", int'(got.frame_type), int'(want.frame_type));
                    compare_field("frame_seq", int'(got.frame_seq), int'(want.frame_seq));
                    compare_field("type_match", int'(got.type_match), int'(want.type_match));
                end
            end
            if (s_tvalid && s_tready) begin
                parse_rx_byte(s_tdata, fires, pred);
                if (row_typed)
                    pending_results.push_back(row_want);
                else if (fires)
                    pending_results.push_back(pred);
            end
        end
    end

    always @(negedge aclk)
        m_tready <= !long_hold && ($urandom_range(99) >= stall_pct);

    initial begin
        forever begin
            @(hold_ev);
            long_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge aclk);
            long_hold <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b, input bit counted);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        if (counted)
            items_sent++;
    endtask

    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        return (b == sld_pkg::SYNC_BYTE) ? ~b : b;
    endfunction

    task automatic send_frame(input logic [7:0] seq, input logic [7:0] ftype,
                              input logic [15:0] len);
        int         i;
        int         tail_pick;
        logic [7:0] t1;
        logic [7:0] t2;
        send_byte(sld_pkg::SYNC_BYTE, 1'b1);
        send_byte(sld_pkg::SYNC_BYTE, 1'b1);
        send_byte(seq, 1'b1);
        send_byte(ftype, 1'b1);
        send_byte(len[7:0], 1'b1);
        send_byte(len[15:8], 1'b1);
        if (len <= shadow_max_payload) begin
            for (i = 0; i < int'(len); i++)
                send_byte(8'($urandom_range(255)), 1'b1);
            tail_pick = $urandom_range(9);
            t1 = sld_pkg::TAIL_BYTE;
            t2 = sld_pkg::TAIL_BYTE;
            if (tail_pick == 7 || tail_pick == 9)
                t1 = sld_pkg::TAIL_BYTE ^ 8'($urandom_range(255, 1));
            if (tail_pick >= 8)
                t2 = sld_pkg::TAIL_BYTE ^ 8'($urandom_range(255, 1));
            send_byte(t1, 1'b1);
            send_byte(t2, 1'b1);
        end
    endtask

    task automatic write_cfg(input logic [7:0] st, input logic [15:0] maxp);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= sld_pkg::CFG_STATE_TYPE;
        cfg_wdata <= {8'h00, st};
        @(posedge aclk);
        shadow_state_type = st;
        @(negedge aclk);
        cfg_index <= sld_pkg::CFG_MAX_PAYLOAD;
        cfg_wdata <= maxp;
        @(posedge aclk);
        shadow_max_payload = maxp;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic await_results();
        int waited;
        waited = 0;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    pending_results.size()));
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        int          i;
        int          ph;
        int          pick;
        int          lo;
        int          hi;
        int          target;
        logic [7:0]  seq;
        logic [7:0]  ftype;
        logic [15:0] len;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < 26; i++) begin
            row_typed <= DIRECTED[i].typed;
            row_want  <= DIRECTED[i].want;
            send_byte(DIRECTED[i].rx, 1'b1);
        end
        row_typed <= 1'b0;
        await_results();

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    write_cfg(8'hFF, 16'hFFFF);
                end
                1: begin
                    send_idle_pct = 82;
                    stall_pct = 0;
                    write_cfg(8'h00, 16'h0000);
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 82;
                    write_cfg(8'($urandom_range(255)), 16'($urandom_range(40, 1)));
                end
                default: begin
                    send_idle_pct = 38;
                    stall_pct = 38;
                    write_cfg(8'($urandom_range(255)), 16'($urandom_range(600, 100)));
                end
            endcase

            // The output is held off while a long frame keeps arriving, so the
            // input must stall; the sender then waits for every result.
            if (ph == 0) begin
                -> hold_ev;
                send_frame(8'($urandom_range(255)), shadow_state_type, 16'd60);
                await_results();
            end

            target = 26 + PHASE_ITEMS * (ph + 1);
            while (items_sent < target) begin
                pick = $urandom_range(99);
                if (pick < 8) begin
                    send_byte(sld_pkg::SYNC_BYTE, 1'b1);
                    send_byte(noise_byte(), 1'b1);
                end else if (pick < 14) begin
                    repeat ($urandom_range(4, 1)) send_byte(noise_byte(), 1'b1);
                end else begin
                    seq = ($urandom_range(9) == 0) ? sld_pkg::SYNC_BYTE
                                                   : 8'($urandom_range(255));
                    ftype = $urandom_range(1) ? shadow_state_type : 8'($urandom_range(255));
                    pick = $urandom_range(99);
                    if (pick < 10 && shadow_max_payload != 16'hFFFF) begin
                        lo = int'(shadow_max_payload) + 1;
                        hi = (lo + 1000 > 65535) ? 65535 : lo + 1000;
                        len = $urandom_range(2) == 0 ? 16'hFFFF : 16'($urandom_range(hi, lo));
                    end else if (pick < 15) begin
                        hi = (shadow_max_payload < 16'd80) ? int'(shadow_max_payload) : 80;
                        len = 16'($urandom_range(hi));
                    end else begin
                        hi = (shadow_max_payload < 16'd12) ? int'(shadow_max_payload) : 12;
                        len = 16'($urandom_range(hi));
                    end
                    send_frame(seq, ftype, len);
                end
            end
            await_results();
        end

        $display("Sent %0d bytes: directed frames, then four register settings with idle,",
                 items_sent);
        $display("stall and back-pressure; results %0d payload, %0d good,",
                 kind_count[sld_pkg::KIND_PAYLOAD], kind_count[sld_pkg::KIND_GOOD]);
        $display("%0d bad tail, %0d oversize.",
                 kind_count[sld_pkg::KIND_BAD_TAIL], kind_count[sld_pkg::KIND_OVERSIZE]);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
